### design/bco_pkg.sv
// ---------------------------------------------------------------------------
// bco_pkg
// shared types and constants of the beacon clock offset tracker
// ---------------------------------------------------------------------------
package bco_pkg;

	localparam int WindowDepthDefault = 50;
	localparam int QueueDepth         = 4;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 48;

	// register indexes of the write port
	localparam logic [CfgIndexW-1:0] CFG_FILTER_ENABLE = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_MATCH_BSSID   = 2'd1;

	// frame control codes
	localparam logic [1:0] TYPE_MGMT      = 2'd0;
	localparam logic [3:0] SUBTYPE_BEACON = 4'd8;

	typedef struct packed {
		logic [62:0] local_time_us;
		logic [62:0] remote_tsf_us;
		logic [47:0] frame_bssid;
		logic [1:0]  frame_type;
		logic [3:0]  frame_subtype;
		logic [15:0] interval_tu;
	} bco_in_t;

	typedef struct packed {
		logic signed [63:0] sync_time_us;
		logic [15:0]        interval_out;
	} bco_out_t;

	typedef struct packed {
		logic        filter_enable;
		logic [47:0] match_bssid;
	} bco_cfg_t;

	// one classified beacon waiting for the back end
	typedef struct packed {
		logic signed [63:0] diff;
		logic [62:0]        remote;
		logic [15:0]        interval;
	} bco_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bco_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_LAST,
		BK_SUM
	} bco_back_state_t;

endpackage

### design/bco_front.sv
// ---------------------------------------------------------------------------
// bco_front
// accepts frames, drops non-beacons and filtered bssids, forms local - remote
// ---------------------------------------------------------------------------
module bco_front (
	input  bco_pkg::bco_in_t    frame,
	input  logic                frame_valid,
	output logic                frame_stall,
	input  bco_pkg::bco_cfg_t   cfg,
	input  bco_pkg::bco_qstat_t qstat,
	output logic                push,
	output bco_pkg::bco_entry_t entry
);
	import bco_pkg::*;

	logic keep;

	always_comb begin
		keep = (frame.frame_type == TYPE_MGMT) && (frame.frame_subtype == SUBTYPE_BEACON)
			&& !(cfg.filter_enable && (frame.frame_bssid != cfg.match_bssid));
	end

	assign frame_stall = qstat.full;
	assign push        = frame_valid && !qstat.full && keep;

	always_comb begin
		entry.diff     = signed'({1'b0, frame.local_time_us} - {1'b0, frame.remote_tsf_us});
		entry.remote   = frame.remote_tsf_us;
		entry.interval = frame.interval_tu;
	end

endmodule

### design/bco_queue.sv
// ---------------------------------------------------------------------------
// bco_queue
// short fifo of classified beacons between front and back
// ---------------------------------------------------------------------------
module bco_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bco_pkg::bco_entry_t push_entry,
	input  logic                pop,
	output bco_pkg::bco_entry_t pop_entry,
	output bco_pkg::bco_qstat_t qstat
);
	import bco_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	bco_entry_t        slot_q [QueueDepth];
	logic [PtrW-1:0]   wptr_q;
	logic [PtrW-1:0]   rptr_q;
	logic [CntW-1:0]   count_q;

	assign qstat.full  = (count_q == CntW'(QueueDepth));
	assign qstat.empty = (count_q == '0);
	assign pop_entry   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && qstat.full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && qstat.empty))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(QueueDepth))
		else $error("queue count out of range");

endmodule

### design/bco_back.sv
// ---------------------------------------------------------------------------
// bco_back
// window memory, sequential minimum scan and output register
// ---------------------------------------------------------------------------
module bco_back #(
	parameter int WINDOW_DEPTH = bco_pkg::WindowDepthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bco_pkg::bco_qstat_t qstat,
	input  bco_pkg::bco_entry_t entry,
	output logic                pop,
	output logic                sync_valid,
	input  logic                sync_stall,
	output bco_pkg::bco_out_t   sync
);
	import bco_pkg::*;

	localparam int IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CntW = $clog2(WINDOW_DEPTH + 1);

	logic signed [63:0] win_mem [WINDOW_DEPTH];
	logic signed [63:0] rd_data_q;

	bco_back_state_t    state_q, state_d;
	logic [IdxW-1:0]    wptr_q;
	logic [CntW-1:0]    fill_q;
	logic [IdxW-1:0]    rd_idx_q;
	logic               rd_pend_q;
	logic signed [63:0] best_q;
	logic [62:0]        remote_q;
	logic [15:0]        interval_q;
	logic               out_valid_q;
	bco_out_t           out_q;

	logic wr_en, rd_en, load_out, scan_done;

	assign scan_done = (rd_idx_q == IdxW'(fill_q - CntW'(1)));

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					wr_en   = 1'b1;
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				rd_en = 1'b1;
				if (scan_done) begin
					state_d = BK_LAST;
				end
			end
			BK_LAST: begin
				state_d = BK_SUM;
			end
			BK_SUM: begin
				if (!out_valid_q || !sync_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// window storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_mem[wptr_q] <= entry.diff;
		end
		if (rd_en) begin
			rd_data_q <= win_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			best_q     <= entry.diff;
			remote_q   <= entry.remote;
			interval_q <= entry.interval;
		end else if (rd_pend_q && (rd_data_q < best_q)) begin
			best_q <= rd_data_q;
		end
		if (load_out) begin
			out_q.sync_time_us <= signed'({1'b0, remote_q} + best_q);
			out_q.interval_out <= interval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wptr_q      <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= rd_en;
			if (pop) begin
				wptr_q   <= (wptr_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				fill_q   <= (fill_q == CntW'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;
				rd_idx_q <= '0;
			end else if (rd_en && !scan_done) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!sync_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sync_valid = out_valid_q;
	assign sync       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CntW'(WINDOW_DEPTH))
		else $error("window fill count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (fill_q != '0))
		else $error("scan with empty window");
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == BK_SUM) && !(out_valid_q && sync_stall)) |=> out_valid_q)
		else $error("finished beacon did not reach output");

endmodule

### design/beacon_clock_offset_tracker_core.sv
// ---------------------------------------------------------------------------
// beacon_clock_offset_tracker_core
// maps beacon timestamps to the local clock with a sliding window minimum
// ---------------------------------------------------------------------------
// each frame item carries local receive time, remote timestamp, bssid, frame
// type/subtype and beacon interval; non-beacons and (with filtering on) frames
// from another bssid are dropped with no result. a kept beacon forms
// diff = local - remote, enters a window of the last WINDOW_DEPTH diffs (the
// first beacon stands for the whole window), and the result is
// remote + min(window) with the interval passed through. the front classifies
// in the accept cycle and pushes kept beacons into a four-item queue; the back
// end writes the diff into the window memory and scans the valid entries with
// one comparator, one read per cycle. a beacon passes through pop and window
// write, the reads of the filled entries, a last compare and the output load,
// which waits while a held output is stalled, and the result is registered.
// the back end takes no new beacon before it is done with the last one. no
// clearing pass is needed: a fill count limits the scan to entries already
// written.
// ---------------------------------------------------------------------------
module beacon_clock_offset_tracker_core #(
	parameter int WINDOW_DEPTH = bco_pkg::WindowDepthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           wr_en,
	input  logic [bco_pkg::CfgIndexW-1:0]  wr_index,
	input  logic [bco_pkg::CfgDataW-1:0]   wr_data,
	// frame items
	input  logic                           frame_valid,
	output logic                           frame_stall,
	input  bco_pkg::bco_in_t               frame,
	// sync time items
	output logic                           sync_valid,
	input  logic                           sync_stall,
	output bco_pkg::bco_out_t              sync
);
	import bco_pkg::*;

	bco_cfg_t   cfg_q;
	bco_qstat_t qstat;
	bco_entry_t push_entry, pop_entry;
	logic       push, pop;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FILTER_ENABLE: cfg_q.filter_enable <= wr_data[0];
				CFG_MATCH_BSSID:   cfg_q.match_bssid   <= wr_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// classify and form the diff
	bco_front u_front (
		.frame       (frame),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.cfg         (cfg_q),
		.qstat       (qstat),
		.push        (push),
		.entry       (push_entry)
	);

	// decouples classification from the window scan
	bco_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	// window update, minimum scan and output register
	bco_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.entry      (pop_entry),
		.pop        (pop),
		.sync_valid (sync_valid),
		.sync_stall (sync_stall),
		.sync       (sync)
	);

endmodule

### dv/tb_beacon_clock_offset_tracker_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_beacon_clock_offset_tracker_core
// self-checking bench for the beacon clock offset tracker
// ---------------------------------------------------------------------------
// frames go in through a valid/stall sender with random gaps. every accepted
// frame runs through a local offset tracker (bssid filter, beacon check,
// sliding window minimum over the last diffs). kept beacons queue an expected
// sync item. a sink with random stalls compares each sync item against the
// oldest expectation. directed tests cover timestamp extremes, frame type
// and subtype codes, the bssid filter and register index range, then a long
// output hold-off fills the block, then random traffic under several filter
// settings runs to the end.
// ---------------------------------------------------------------------------
module tb_beacon_clock_offset_tracker_core;

	import bco_pkg::*;

	localparam int WINDOW_DEPTH = WindowDepthDefault;
	// leave margin for the back end to finish a beacon once the window is full
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PRINT_CAP    = 200;

	// indexes past the register list, written to see that they are ignored
	localparam logic [CfgIndexW-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CfgIndexW-1:0] CFG_SPARE_HI = 2'd3;

	localparam logic [62:0] TS_MAX    = {63{1'b1}};
	localparam logic [47:0] BSSID_MAX = {48{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CfgIndexW-1:0] wr_index;
	logic [CfgDataW-1:0]  wr_data;
	logic                 frame_valid;
	logic                 frame_stall;
	bco_in_t              frame;
	logic                 sync_valid;
	logic                 sync_stall;
	bco_out_t             sync;

	beacon_clock_offset_tracker_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame      (frame),
		.sync_valid (sync_valid),
		.sync_stall (sync_stall),
		.sync       (sync)
	);

	// local copy of the block's registers and tracking state
	logic               cfg_filter;
	logic [47:0]        cfg_bssid;
	logic signed [63:0] offset_hist [WINDOW_DEPTH];
	logic               offset_primed;
	logic signed [63:0] cur_offset;

	// sync items the tracker still owes, oldest first
	bco_out_t sync_expected [$];

	// offset that the random local clocks sit at, changed per phase
	logic [62:0] phase_offset;

	// idling controls of the sender and the sink
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_request;

	int cycle_count;
	int mismatch_count;
	int frames_sent;
	int beacons_kept;
	int frames_dropped;
	int syncs_checked;
	int stall_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sync items outstanding",
				cycle_count, sync_expected.size());
			$display("** beacon_clock_offset_tracker_core: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// offset tracker: filter, beacon check, window shift and signed minimum
	function automatic void track_offset(input bco_in_t f);
		logic signed [63:0] diff;
		logic signed [63:0] best;
		bco_out_t           want;
		if (cfg_filter && f.frame_bssid != cfg_bssid) begin
			frames_dropped++;
			return;
		end
		if (f.frame_type != TYPE_MGMT || f.frame_subtype != SUBTYPE_BEACON) begin
			frames_dropped++;
			return;
		end
		diff = {1'b0, f.local_time_us} - {1'b0, f.remote_tsf_us};
		// the first beacon stands for the whole window
		if (!offset_primed) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				offset_hist[i] = diff;
			offset_primed = 1'b1;
		end
		for (int i = 0; i + 1 < WINDOW_DEPTH; i++)
			offset_hist[i] = offset_hist[i + 1];
		offset_hist[WINDOW_DEPTH - 1] = diff;
		best = offset_hist[0];
		for (int i = 1; i < WINDOW_DEPTH; i++)
			if (offset_hist[i] < best)
				best = offset_hist[i];
		cur_offset = best;
		want.sync_time_us = {1'b0, f.remote_tsf_us} + best;
		want.interval_out = f.interval_tu;
		sync_expected.push_back(want);
		beacons_kept++;
	endfunction

	// register write, only while the block is idle
	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_FILTER_ENABLE)
			cfg_filter = data[0];
		else if (idx == CFG_MATCH_BSSID)
			cfg_bssid = data;
	endtask

	// offer one item, hold it until accepted, then predict its result
	task automatic send_frame(input bco_in_t item);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 14) : 0;
		repeat (gap) begin
			@(negedge clk);
			frame_valid <= 1'b0;
		end
		@(negedge clk);
		frame_valid <= 1'b1;
		frame       <= item;
		@(posedge clk);
		while (frame_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		frames_sent++;
		track_offset(item);
	endtask

	// drop valid, wait for every owed sync item, then let the back end settle
	task automatic wait_idle();
		@(negedge clk);
		frame_valid <= 1'b0;
		while (sync_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic bco_in_t frame_of(input logic [62:0] lt, input logic [62:0] rt,
			input logic [47:0] bssid, input logic [1:0] ftype, input logic [3:0] fsub,
			input logic [15:0] interval);
		bco_in_t f;
		f.local_time_us = lt;
		f.remote_tsf_us = rt;
		f.frame_bssid   = bssid;
		f.frame_type    = ftype;
		f.frame_subtype = fsub;
		f.interval_tu   = interval;
		return f;
	endfunction

	// random frame: mostly local = remote + phase offset + jitter
	function automatic bco_in_t make_frame(input bit as_beacon, input bit bssid_hit);
		bco_in_t     f;
		logic [63:0] r;
		r = {$urandom, $urandom};
		f.remote_tsf_us = r[62:0];
		if ($urandom_range(0, 4) == 0) begin
			r = {$urandom, $urandom};
			f.local_time_us = r[62:0];
		end else begin
			f.local_time_us = f.remote_tsf_us + phase_offset + 63'($urandom_range(0, 2000));
		end
		r = {$urandom, $urandom};
		if (bssid_hit)
			f.frame_bssid = cfg_bssid;
		else if ($urandom_range(0, 1))
			f.frame_bssid = cfg_bssid ^ (48'd1 << $urandom_range(0, 47));
		else
			f.frame_bssid = r[47:0];
		if (as_beacon) begin
			f.frame_type    = TYPE_MGMT;
			f.frame_subtype = SUBTYPE_BEACON;
		end else begin
			// near misses of the beacon code as well as other classes
			do begin
				f.frame_type    = $urandom_range(0, 1) ? TYPE_MGMT : 2'($urandom);
				f.frame_subtype = $urandom_range(0, 2) == 0 ? SUBTYPE_BEACON : 4'($urandom);
			end while (f.frame_type == TYPE_MGMT && f.frame_subtype == SUBTYPE_BEACON);
		end
		f.interval_tu = 16'($urandom);
		return f;
	endfunction

	// sync sink: random stall before each item, one long hold on request
	initial begin : sync_sink
		int       wait_n;
		bco_out_t want;
		sync_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = rx_idle_on ? $urandom_range(0, 14) : 0;
			if (hold_request) begin
				wait_n       = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (wait_n > 0) begin
				repeat (wait_n) begin
					@(negedge clk);
					sync_stall <= 1'b1;
				end
				@(negedge clk);
				sync_stall <= 1'b0;
			end
			@(posedge clk);
			while (!sync_valid)
				@(posedge clk);
			syncs_checked++;
			if (sync_expected.size() == 0) begin
				report_mismatch($sformatf("sync item %h/%h with no beacon pending",
					sync.sync_time_us, sync.interval_out));
			end else begin
				want = sync_expected.pop_front();
				if (sync.sync_time_us !== want.sync_time_us)
					report_mismatch($sformatf("sync_time_us got %h want %h",
						sync.sync_time_us, want.sync_time_us));
				if (sync.interval_out !== want.interval_out)
					report_mismatch($sformatf("interval_out got %h want %h",
						sync.interval_out, want.interval_out));
			end
		end
	end

	// timestamp extremes and every frame class with the filter off
	task automatic test_beacon_classes();
		// first beacon fills the window
		send_frame(frame_of('0, '0, '0, TYPE_MGMT, SUBTYPE_BEACON, 16'h0000));
		// largest positive and largest negative diff
		send_frame(frame_of(TS_MAX, '0, BSSID_MAX, TYPE_MGMT, SUBTYPE_BEACON, 16'hffff));
		send_frame(frame_of('0, TS_MAX, '0, TYPE_MGMT, SUBTYPE_BEACON, 16'h0064));
		send_frame(frame_of(TS_MAX, TS_MAX, 48'h5555_5555_5555, TYPE_MGMT,
			SUBTYPE_BEACON, 16'haaaa));
		// frames that are not beacons
		send_frame(frame_of(63'd10, 63'd5, '0, 2'd1, SUBTYPE_BEACON, 16'h1111));
		send_frame(frame_of(63'd10, 63'd5, '0, 2'd2, SUBTYPE_BEACON, 16'h2222));
		send_frame(frame_of(63'd10, 63'd5, '0, 2'd3, 4'd15, 16'h3333));
		send_frame(frame_of(63'd10, 63'd5, '0, TYPE_MGMT, 4'd0, 16'h4444));
		send_frame(frame_of(63'd10, 63'd5, '0, TYPE_MGMT, 4'd9, 16'h5555));
		send_frame(frame_of(63'd10, 63'd5, '0, TYPE_MGMT, 4'd7, 16'h6666));
		send_frame(frame_of(63'd3000, 63'd1000, 48'h0123_4567_89ab, TYPE_MGMT,
			SUBTYPE_BEACON, 16'h0100));
	endtask

	// bssid filter at both register extremes
	task automatic test_bssid_filter();
		wait_idle();
		write_reg(CFG_MATCH_BSSID, BSSID_MAX);
		write_reg(CFG_FILTER_ENABLE, 48'd1);
		send_frame(frame_of(63'd500, 63'd100, BSSID_MAX, TYPE_MGMT, SUBTYPE_BEACON, 16'd7));
		send_frame(frame_of(63'd500, 63'd100, BSSID_MAX ^ 48'd1, TYPE_MGMT,
			SUBTYPE_BEACON, 16'd8));
		send_frame(frame_of(63'd500, 63'd100, '0, TYPE_MGMT, SUBTYPE_BEACON, 16'd9));
		// matching bssid but not a beacon
		send_frame(frame_of(63'd500, 63'd100, BSSID_MAX, TYPE_MGMT, 4'd5, 16'd10));
		wait_idle();
		write_reg(CFG_MATCH_BSSID, '0);
		send_frame(frame_of(63'd900, 63'd800, '0, TYPE_MGMT, SUBTYPE_BEACON, 16'd11));
		send_frame(frame_of(63'd900, 63'd800, 48'h8000_0000_0000, TYPE_MGMT,
			SUBTYPE_BEACON, 16'd12));
	endtask

	// spare indexes change nothing, upper data bits of the enable are ignored
	task automatic test_register_index_range();
		logic [63:0] r;
		wait_idle();
		r = {$urandom, $urandom};
		write_reg(CFG_SPARE_LO, r[47:0] | 48'd1);
		r = {$urandom, $urandom};
		write_reg(CFG_SPARE_HI, r[47:0] | 48'd1);
		// filter still on with bssid zero
		send_frame(frame_of(63'd1500, 63'd1400, '0, TYPE_MGMT, SUBTYPE_BEACON, 16'd13));
		send_frame(frame_of(63'd1500, 63'd1400, r[47:0] | 48'd1, TYPE_MGMT,
			SUBTYPE_BEACON, 16'd14));
		wait_idle();
		write_reg(CFG_FILTER_ENABLE, 48'hffff_ffff_fffe);
		send_frame(frame_of(63'd1600, 63'd1500, r[47:0] | 48'd1, TYPE_MGMT,
			SUBTYPE_BEACON, 16'd15));
	endtask

	// sink holds off while beacons keep coming, so the input side stalls
	task automatic test_output_backpressure();
		wait_idle();
		tx_idle_on   = 1'b0;
		hold_request = 1'b1;
		phase_offset = 63'd250;
		repeat (16) send_frame(make_frame(1'b1, 1'b0));
		tx_idle_on = 1'b1;
	endtask

	// random traffic under one filter setting, with idle-free stretches
	task automatic test_random_traffic(input int n_items, input bit filter_on,
			input logic [47:0] bssid);
		logic [63:0] r;
		bit          beacon;
		bit          hit;
		wait_idle();
		r = {$urandom, $urandom};
		write_reg(CFG_FILTER_ENABLE, {r[47:1], filter_on});
		write_reg(CFG_MATCH_BSSID, bssid);
		r = {$urandom, $urandom};
		phase_offset = r[62:0];
		for (int i = 0; i < n_items; i++) begin
			tx_idle_on = ((i / 40) % 3) != 2;
			rx_idle_on = ((i / 40) % 4) != 3;
			beacon     = $urandom_range(0, 99) < 80;
			hit        = filter_on && ($urandom_range(0, 9) < 8);
			send_frame(make_frame(beacon, hit));
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin : main_seq
		logic [63:0] r;
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = CFG_FILTER_ENABLE;
		wr_data        = '0;
		frame_valid    = 1'b0;
		frame          = '0;
		cfg_filter     = 1'b0;
		cfg_bssid      = '0;
		offset_primed  = 1'b0;
		cur_offset     = '0;
		phase_offset   = '0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		hold_request   = 1'b0;
		cycle_count    = 0;
		mismatch_count = 0;
		frames_sent    = 0;
		beacons_kept   = 0;
		frames_dropped = 0;
		syncs_checked  = 0;
		stall_cycles   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_beacon_classes();
		test_bssid_filter();
		test_register_index_range();
		test_output_backpressure();
		r = {$urandom, $urandom};
		test_random_traffic(175, 1'b0, r[47:0]);
		r = {$urandom, $urandom};
		test_random_traffic(175, 1'b1, r[47:0]);
		test_random_traffic(175, 1'b1, '0);
		test_random_traffic(175, 1'b1, BSSID_MAX);
		wait_idle();

		$display("covered %0d frames: %0d beacons tracked, %0d dropped by type or bssid",
			frames_sent, beacons_kept, frames_dropped);
		$display("checked %0d sync items, %0d input stall cycles, %0d mismatches",
			syncs_checked, stall_cycles, mismatch_count);
		if (mismatch_count == 0 && sync_expected.size() == 0)
			$display("** beacon_clock_offset_tracker_core: PASSED **");
		else
			$display("** beacon_clock_offset_tracker_core: FAILED **");
		$finish;
	end

endmodule

### filelist.f
design/bco_pkg.sv
design/bco_front.sv
design/bco_queue.sv
design/bco_back.sv
design/beacon_clock_offset_tracker_core.sv
dv/tb_beacon_clock_offset_tracker_core.sv
